/* rtl/bscs_pkg.sv */
// Shared types and constants for the Bezier speed-curve sampler.
// Used by bscs_ctrl, bscs_dpath and bezier_speed_curve_sampler; depends on nothing.
package bscs_pkg;

  localparam logic [16:0] X_ONE = 17'd65536;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SPAN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LENGTH = 8'd1;

  // Divider iteration counts, each stored as count minus one.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEPS_SPAN = 6'd48;
  localparam logic [STEP_W-1:0] STEPS_CNT  = 6'd48;
  localparam logic [STEP_W-1:0] STEPS_DX   = 6'd16;
  localparam logic [STEP_W-1:0] STEPS_BEZ  = 6'd39;

  typedef enum logic [1:0] {
    DIV_SPAN,
    DIV_CNT,
    DIV_DX,
    DIV_BEZ
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULH,
    ST_DLOAD,
    ST_DRUN,
    ST_DDONE,
    ST_N2,
    ST_N3,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_W4,
    ST_P0,
    ST_P1,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic    load_pt;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_load;
    div_op_t div_op;
    logic    div_step;
    logic    take_ss;
    logic    take_cnt;
    logic    take_dxq;
    logic    n2;
    logic    n3;
    logic    w1a;
    logic    w1b;
    logic    s0;
    logic    s1;
    logic    p0;
    logic    p1;
    logic    take_out;
    logic    adv;
  } cmd_t;

  typedef struct packed {
    logic no_prev;
    logic skip_pre;
    logic q_zero;
    logic last;
  } stat_t;

endpackage

/* rtl/bscs_ctrl.sv */
// Sequencer for the sampler: walks each point through span, count and step divisions,
// then each sample through weight, product and Bezier division. Uses bscs_pkg.
module bscs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  output logic            unit_valid,
  input  logic            unit_ready,
  input  bscs_pkg::stat_t st,
  output bscs_pkg::cmd_t  cmd
);

  bscs_pkg::state_t  state, state_next;
  bscs_pkg::div_op_t op, op_next;
  logic [bscs_pkg::STEP_W-1:0] step, step_next, last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bscs_pkg::ST_IDLE;
      op    <= bscs_pkg::DIV_SPAN;
      step  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      step  <= step_next;
    end
  end

  always_comb begin
    unique case (op)
      bscs_pkg::DIV_SPAN: last_step = bscs_pkg::STEPS_SPAN;
      bscs_pkg::DIV_CNT:  last_step = bscs_pkg::STEPS_CNT;
      bscs_pkg::DIV_DX:   last_step = bscs_pkg::STEPS_DX;
      default:            last_step = bscs_pkg::STEPS_BEZ;
    endcase
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    step_next   = step;
    point_ready = 1'b0;
    unit_valid  = 1'b0;
    cmd         = '0;
    cmd.div_op  = op;
    unique case (state)
      bscs_pkg::ST_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          cmd.load_pt = 1'b1;
          if (!st.no_prev) state_next = bscs_pkg::ST_CHECK;
        end
      end
      bscs_pkg::ST_CHECK: begin
        if (st.skip_pre) begin
          state_next = bscs_pkg::ST_IDLE;
        end else begin
          cmd.mul_lo = 1'b1;
          state_next = bscs_pkg::ST_MULH;
        end
      end
      bscs_pkg::ST_MULH: begin
        cmd.mul_hi = 1'b1;
        op_next    = bscs_pkg::DIV_SPAN;
        state_next = bscs_pkg::ST_DLOAD;
      end
      bscs_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = bscs_pkg::ST_DRUN;
      end
      bscs_pkg::ST_DRUN: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == last_step) state_next = bscs_pkg::ST_DDONE;
      end
      bscs_pkg::ST_DDONE: begin
        unique case (op)
          bscs_pkg::DIV_SPAN: begin
            cmd.take_ss = 1'b1;
            op_next     = bscs_pkg::DIV_CNT;
            state_next  = bscs_pkg::ST_DLOAD;
          end
          bscs_pkg::DIV_CNT: begin
            if (st.q_zero) begin
              state_next = bscs_pkg::ST_IDLE;
            end else begin
              cmd.take_cnt = 1'b1;
              op_next      = bscs_pkg::DIV_DX;
              state_next   = bscs_pkg::ST_DLOAD;
            end
          end
          bscs_pkg::DIV_DX: begin
            cmd.take_dxq = 1'b1;
            state_next   = bscs_pkg::ST_N2;
          end
          default: begin
            cmd.take_out = 1'b1;
            state_next   = bscs_pkg::ST_OUT;
          end
        endcase
      end
      bscs_pkg::ST_N2: begin
        cmd.n2     = 1'b1;
        state_next = bscs_pkg::ST_N3;
      end
      bscs_pkg::ST_N3: begin
        cmd.n3     = 1'b1;
        state_next = bscs_pkg::ST_W1;
      end
      bscs_pkg::ST_W1: begin
        cmd.w1a    = 1'b1;
        state_next = bscs_pkg::ST_W2;
      end
      bscs_pkg::ST_W2: begin
        cmd.w1b    = 1'b1;
        state_next = bscs_pkg::ST_W3;
      end
      bscs_pkg::ST_W3: begin
        cmd.s0     = 1'b1;
        state_next = bscs_pkg::ST_W4;
      end
      bscs_pkg::ST_W4: begin
        cmd.s1     = 1'b1;
        state_next = bscs_pkg::ST_P0;
      end
      bscs_pkg::ST_P0: begin
        cmd.p0     = 1'b1;
        state_next = bscs_pkg::ST_P1;
      end
      bscs_pkg::ST_P1: begin
        cmd.p1     = 1'b1;
        op_next    = bscs_pkg::DIV_BEZ;
        state_next = bscs_pkg::ST_DLOAD;
      end
      bscs_pkg::ST_OUT: begin
        unit_valid = 1'b1;
        if (unit_ready) begin
          if (st.last) begin
            state_next = bscs_pkg::ST_IDLE;
          end else begin
            cmd.adv    = 1'b1;
            state_next = bscs_pkg::ST_W1;
          end
        end
      end
      default: state_next = bscs_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/bscs_dpath.sv */
// Datapath of the sampler: configuration, stored point, multipliers, a shared
// restoring divider and the sample registers. Uses bscs_pkg; driven by bscs_ctrl.
module bscs_dpath #(
  parameter int MAX_UNITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [bscs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]                    cfg_data,
  input  logic [16:0]                    point_x,
  input  logic [15:0]                    point_y,
  input  logic                           starts_list,
  input  bscs_pkg::cmd_t                 cmd,
  output bscs_pkg::stat_t                st,
  output logic [16:0]                    unit_x,
  output logic [39:0]                    unit_y_scaled,
  output logic [16:0]                    segment_begin_x,
  output logic [16:0]                    segment_end_x,
  output logic                           last_of_run,
  output logic                           count_clamped
);

  localparam int NW    = $clog2(MAX_UNITS + 1);
  localparam int N3_W  = 3 * NW;
  localparam int SA_W  = 16 + N3_W;
  localparam int NA_W  = 40 + N3_W;
  localparam int DV_W  = (NA_W > 50) ? NA_W : 50;
  localparam int DVS_W = (N3_W > 24) ? N3_W : 24;
  localparam int T3_W  = NW + 2;

  logic [39:0] total_span;
  logic [23:0] unit_length;
  logic [16:0] prev_x, x0, x1;
  logic [15:0] prev_y, y0, y1;
  logic        have_prev;

  logic [16:0] x_sat, dx;
  logic [16:0] ysum;
  logic [36:0] mlo, mprod;
  logic [56:0] span_full;
  logic [39:0] span;
  logic [48:0] ss;

  logic [DVS_W-1:0] dvs, rem, dvs0, rem0;
  logic [DV_W-1:0]  dsr, dsr0;
  logic [DVS_W:0]   sh;
  logic             ge;

  logic [NW-1:0]   n, i, r, dr;
  logic            clamped;
  logic [16:0]     q, dq;
  logic [2*NW-1:0] n2, ii;
  logic [N3_W-1:0] n3, w1;
  logic [T3_W-1:0] t3;
  logic [SA_W-1:0] sacc;
  logic [NA_W-1:0] nacc;
  logic [NW:0]     rs;
  logic [17:0]     ux;

  assign x_sat = (point_x > bscs_pkg::X_ONE) ? bscs_pkg::X_ONE : point_x;
  assign ysum  = {1'b0, y0} + {1'b0, y1};
  assign dx    = (x1 >= x0) ? (x1 - x0) : (x0 - x1);

  // The low half of the span product is registered; the high half joins it next cycle.
  assign mprod     = 37'(cmd.mul_lo ? total_span[19:0] : total_span[39:20]) * 37'(dx);
  assign span_full = {mprod, 20'd0} + {20'd0, mlo};

  assign st.no_prev  = starts_list || !have_prev;
  assign st.skip_pre = (ysum == 17'd0) || (unit_length == 24'd0);
  assign st.q_zero   = (dsr == '0);
  assign st.last     = (i == n - 1'b1);

  always_comb begin
    unique case (cmd.div_op)
      bscs_pkg::DIV_SPAN: begin
        dvs0 = DVS_W'(ysum);
        rem0 = '0;
        dsr0 = DV_W'({span, 9'd0}) << (DV_W - 49);
      end
      bscs_pkg::DIV_CNT: begin
        dvs0 = DVS_W'(unit_length);
        rem0 = '0;
        dsr0 = DV_W'(ss) << (DV_W - 49);
      end
      bscs_pkg::DIV_DX: begin
        dvs0 = DVS_W'(n);
        rem0 = '0;
        dsr0 = DV_W'(dx) << (DV_W - 17);
      end
      default: begin
        // The quotient fits in 40 bits, so the upper part of the product already lies below n^3.
        dvs0 = DVS_W'(n3);
        rem0 = DVS_W'(nacc[NA_W-1:40]);
        dsr0 = DV_W'(nacc[39:0]) << (DV_W - 40);
      end
    endcase
  end

  assign sh = {rem, dsr[DV_W-1]};
  assign ge = (sh >= {1'b0, dvs});
  assign rs = {1'b0, r} + {1'b0, dr};
  assign ux = {1'b0, x0} + {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      total_span  <= '0;
      unit_length <= 24'd1;
      prev_x      <= '0;
      prev_y      <= '0;
      have_prev   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == bscs_pkg::CFG_TOTAL_SPAN) total_span <= cfg_data;
        if (cfg_index == bscs_pkg::CFG_UNIT_LENGTH) unit_length <= cfg_data[23:0];
      end
      if (cmd.load_pt) begin
        prev_x    <= x_sat;
        prev_y    <= point_y;
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      x0 <= prev_x;
      y0 <= prev_y;
      x1 <= x_sat;
      y1 <= point_y;
    end
    if (cmd.mul_lo) mlo <= mprod;
    if (cmd.mul_hi) span <= span_full[55:16];
    if (cmd.div_load) begin
      dvs <= dvs0;
      rem <= rem0;
      dsr <= dsr0;
    end else if (cmd.div_step) begin
      rem <= ge ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
      dsr <= {dsr[DV_W-2:0], ge};
    end
    if (cmd.take_ss) ss <= dsr[48:0];
    if (cmd.take_cnt) begin
      if (dsr > DV_W'(MAX_UNITS)) begin
        n       <= NW'(MAX_UNITS);
        clamped <= 1'b1;
      end else begin
        n       <= dsr[NW-1:0];
        clamped <= 1'b0;
      end
    end
    if (cmd.take_dxq) begin
      dq <= dsr[16:0];
      dr <= rem[NW-1:0];
      i  <= '0;
      q  <= '0;
      r  <= '0;
    end
    if (cmd.n2) n2 <= {{NW{1'b0}}, n} * {{NW{1'b0}}, n};
    if (cmd.n3) n3 <= N3_W'(n2) * N3_W'(n);
    if (cmd.w1a) begin
      ii <= {{NW{1'b0}}, i} * {{NW{1'b0}}, i};
      t3 <= ({2'b00, n} + {1'b0, n, 1'b0}) - {1'b0, i, 1'b0};
    end
    if (cmd.w1b) w1 <= N3_W'(ii) * N3_W'(t3);
    if (cmd.s0) sacc <= SA_W'(y0) * SA_W'(n3 - w1);
    if (cmd.s1) sacc <= sacc + SA_W'(y1) * SA_W'(w1);
    if (cmd.p0) nacc <= NA_W'(sacc) * NA_W'(unit_length[11:0]);
    if (cmd.p1) nacc <= nacc + ((NA_W'(sacc) * NA_W'(unit_length[23:12])) << 12);
    if (cmd.take_out) begin
      unit_y_scaled <= dsr[39:0];
      unit_x        <= (ux > {1'b0, bscs_pkg::X_ONE}) ? bscs_pkg::X_ONE : ux[16:0];
    end
    // Step position: q, r track floor(i*dx/n) and its remainder.
    if (cmd.adv) begin
      i <= i + 1'b1;
      if (rs >= {1'b0, n}) begin
        r <= NW'(rs - {1'b0, n});
        q <= q + dq + 17'd1;
      end else begin
        r <= rs[NW-1:0];
        q <= q + dq;
      end
    end
  end

  assign segment_begin_x = x0;
  assign segment_end_x   = x1;
  assign last_of_run     = st.last;
  assign count_clamped   = clamped;

endmodule

/* rtl/bezier_speed_curve_sampler.sv */
// Top level of the Bezier speed-curve sampler: joins the sequencer and the datapath.
// Depends on bscs_pkg, bscs_ctrl and bscs_dpath.
//
//   channel  direction  handshake             payload
//   point    in         point_valid/ready     point_x, point_y, starts_list
//   unit     out        unit_valid/ready      unit_x, unit_y_scaled, segment_begin_x,
//                                             segment_end_x, last_of_run, count_clamped
//   cfg      in         cfg_valid/ready       cfg_index, cfg_data
//
// A point that starts a list is only stored and the sequencer stays idle. A full segment
// first runs setup (two 49-step divisions and a 17-step division in the shared serial
// divider), then the weight products and the 40-step Bezier division for each sample.
// Skipped pairs go idle after the check, or after the count division on a zero count.
// Reset is synchronous and clears the sequencer, the stored point and the span setting.
// A beat waiting on the unit channel holds the block; points are taken only when idle.
module bezier_speed_curve_sampler #(
  parameter int MAX_UNITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bscs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]                    cfg_data,
  input  logic                           point_valid,
  output logic                           point_ready,
  input  logic [16:0]                    point_x,
  input  logic [15:0]                    point_y,
  input  logic                           starts_list,
  output logic                           unit_valid,
  input  logic                           unit_ready,
  output logic [16:0]                    unit_x,
  output logic [39:0]                    unit_y_scaled,
  output logic [16:0]                    segment_begin_x,
  output logic [16:0]                    segment_end_x,
  output logic                           last_of_run,
  output logic                           count_clamped
);

  bscs_pkg::cmd_t  cmd;
  bscs_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  bscs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .st          (st),
    .cmd         (cmd)
  );

  bscs_dpath #(
    .MAX_UNITS (MAX_UNITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .point_x         (point_x),
    .point_y         (point_y),
    .starts_list     (starts_list),
    .cmd             (cmd),
    .st              (st),
    .unit_x          (unit_x),
    .unit_y_scaled   (unit_y_scaled),
    .segment_begin_x (segment_begin_x),
    .segment_end_x   (segment_end_x),
    .last_of_run     (last_of_run),
    .count_clamped   (count_clamped)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(point_ready && unit_valid))
    else $error("point taken while a sample beat is pending");

  a_x_range: assert property (@(posedge clk) disable iff (rst)
    unit_valid |-> (unit_x <= bscs_pkg::X_ONE))
    else $error("sample position above 1.0");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && unit_ready && !last_of_run) |=> !point_ready)
    else $error("segment ended before its last sample");

endmodule
